// ===== rtl/core/slac_pkg.sv =====
// Package for the SKINNY-64-64 linear approximation counter.
// Holds defaults, register indexes, command/status types and round functions.
// No dependencies.
package slac_pkg;

  localparam int DefCountBits = 32;
  localparam int DefMaxRounds = 32;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_KEY    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ROUNDS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_IMASK  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_OMASK  = 2'd3;

  localparam logic [5:0] ROUNDS_RESET = 6'd6;
  localparam logic [3:0] RC_ROW2      = 4'h2;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic rounds_done;
    logic out_full;
  } dp_sts_t;

  function automatic logic [3:0] sbox4(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hc;
      4'h1: y = 4'h6;
      4'h2: y = 4'h9;
      4'h3: y = 4'h0;
      4'h4: y = 4'h1;
      4'h5: y = 4'ha;
      4'h6: y = 4'h2;
      4'h7: y = 4'hb;
      4'h8: y = 4'h3;
      4'h9: y = 4'h8;
      4'ha: y = 4'h5;
      4'hb: y = 4'hd;
      4'hc: y = 4'h4;
      4'hd: y = 4'he;
      4'he: y = 4'h7;
      default: y = 4'hf;
    endcase
    return y;
  endfunction

  function automatic logic [3:0] rc_low(input logic [4:0] r);
    logic [3:0] y;
    case (r)
      5'd0:  y = 4'h1;  5'd1:  y = 4'h3;  5'd2:  y = 4'h7;  5'd3:  y = 4'hf;
      5'd4:  y = 4'hf;  5'd5:  y = 4'he;  5'd6:  y = 4'hd;  5'd7:  y = 4'hb;
      5'd8:  y = 4'h7;  5'd9:  y = 4'hf;  5'd10: y = 4'he;  5'd11: y = 4'hc;
      5'd12: y = 4'h9;  5'd13: y = 4'h3;  5'd14: y = 4'h7;  5'd15: y = 4'he;
      5'd16: y = 4'hd;  5'd17: y = 4'ha;  5'd18: y = 4'h5;  5'd19: y = 4'hb;
      5'd20: y = 4'h6;  5'd21: y = 4'hc;  5'd22: y = 4'h8;  5'd23: y = 4'h0;
      5'd24: y = 4'h1;  5'd25: y = 4'h2;  5'd26: y = 4'h5;  5'd27: y = 4'hb;
      5'd28: y = 4'h7;  5'd29: y = 4'he;  5'd30: y = 4'hc;
      default: y = 4'h8;
    endcase
    return y;
  endfunction

  function automatic logic [3:0] rc_high(input logic [4:0] r);
    logic [3:0] y;
    case (r)
      5'd0:  y = 4'h0;  5'd1:  y = 4'h0;  5'd2:  y = 4'h0;  5'd3:  y = 4'h0;
      5'd4:  y = 4'h1;  5'd5:  y = 4'h3;  5'd6:  y = 4'h3;  5'd7:  y = 4'h3;
      5'd8:  y = 4'h3;  5'd9:  y = 4'h2;  5'd10: y = 4'h1;  5'd11: y = 4'h3;
      5'd12: y = 4'h3;  5'd13: y = 4'h3;  5'd14: y = 4'h2;  5'd15: y = 4'h0;
      5'd16: y = 4'h1;  5'd17: y = 4'h3;  5'd18: y = 4'h3;  5'd19: y = 4'h2;
      5'd20: y = 4'h1;  5'd21: y = 4'h2;  5'd22: y = 4'h1;  5'd23: y = 4'h3;
      5'd24: y = 4'h2;  5'd25: y = 4'h0;  5'd26: y = 4'h0;  5'd27: y = 4'h0;
      5'd28: y = 4'h1;  5'd29: y = 4'h2;  5'd30: y = 4'h1;
      default: y = 4'h3;
    endcase
    return y;
  endfunction

  function automatic logic [3:0] tk_perm(input logic [3:0] j);
    logic [3:0] y;
    case (j)
      4'd0:  y = 4'd9;  4'd1:  y = 4'd15; 4'd2:  y = 4'd8;  4'd3:  y = 4'd13;
      4'd4:  y = 4'd10; 4'd5:  y = 4'd14; 4'd6:  y = 4'd12; 4'd7:  y = 4'd11;
      4'd8:  y = 4'd0;  4'd9:  y = 4'd1;  4'd10: y = 4'd2;  4'd11: y = 4'd3;
      4'd12: y = 4'd4;  4'd13: y = 4'd5;  4'd14: y = 4'd6;
      default: y = 4'd7;
    endcase
    return y;
  endfunction

  function automatic logic [63:0] permute_tk(input logic [63:0] tk);
    logic [3:0] a [16];
    logic [63:0] v;
    for (int j = 0; j < 16; j++) begin
      a[j] = tk[63-4*j -: 4];
    end
    v = '0;
    for (int j = 0; j < 16; j++) begin
      v[63-4*j -: 4] = a[tk_perm(4'(j))];
    end
    return v;
  endfunction

  function automatic logic [63:0] skinny_round(input logic [63:0] st,
                                               input logic [63:0] tk,
                                               input logic [4:0]  r);
    logic [3:0] s [16];
    logic [3:0] t [16];
    logic [63:0] v;
    for (int j = 0; j < 16; j++) begin
      s[j] = sbox4(st[63-4*j -: 4]);
    end
    s[0] = s[0] ^ rc_low(r);
    s[4] = s[4] ^ rc_high(r);
    s[8] = s[8] ^ RC_ROW2;
    for (int j = 0; j < 8; j++) begin
      s[j] = s[j] ^ tk[63-4*j -: 4];
    end
    for (int i = 0; i < 4; i++) begin
      t[i]      = s[i];
      t[i + 4]  = s[((i + 3) % 4) + 4];
      t[i + 8]  = s[((i + 2) % 4) + 8];
      t[i + 12] = s[((i + 1) % 4) + 12];
    end
    for (int i = 0; i < 4; i++) begin
      s[i]      = t[i] ^ t[i + 8] ^ t[i + 12];
      s[i + 4]  = t[i];
      s[i + 8]  = t[i + 4] ^ t[i + 8];
      s[i + 12] = t[i] ^ t[i + 8];
    end
    v = '0;
    for (int j = 0; j < 16; j++) begin
      v[63-4*j -: 4] = s[j];
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/slac_ctrl.sv =====
// Controller for the linear approximation counter: idle/run sequencing.
// Issues load, step and finish commands to slac_dp. Depends on slac_pkg.
module slac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  input  slac_pkg::dp_sts_t sts,
  output slac_pkg::dp_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_free;

  assign out_free = !sts.out_full || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (!sts.rounds_done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/slac_dp.sv =====
// Datapath: one SKINNY-64-64 round per cycle, tweakey schedule, parity and
// saturating match counter with the output register. Depends on slac_pkg.
module slac_dp #(
  parameter int COUNT_BITS = slac_pkg::DefCountBits,
  parameter int MAX_ROUNDS = slac_pkg::DefMaxRounds
) (
  input  logic              clk,
  input  logic              rst_n,
  input  slac_pkg::dp_cmd_t cmd,
  output slac_pkg::dp_sts_t sts,
  input  logic [63:0]       in_plaintext,
  input  logic              in_restart,
  input  logic [63:0]       cipher_key,
  input  logic [5:0]        round_count,
  input  logic [63:0]       input_mask,
  input  logic [63:0]       output_mask,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       out_ciphertext,
  output logic              out_approx_parity,
  output logic [31:0]       out_match_total
);

  localparam int IdxW = $clog2(MAX_ROUNDS + 1);

  logic [63:0]           state_r, tk_r, pt_r;
  logic [IdxW-1:0]       idx_r, rounds_r;
  logic                  restart_r;
  logic [COUNT_BITS-1:0] count_r, count_nxt, count_base;
  logic                  out_valid_r;
  logic [63:0]           ct_r;
  logic                  par_r;
  logic [31:0]           total_r;
  logic [IdxW-1:0]       rounds_sat;
  logic                  par;

  assign rounds_sat = (round_count > 6'(MAX_ROUNDS)) ? IdxW'(MAX_ROUNDS)
                                                     : IdxW'(round_count);

  assign par = ^((input_mask & pt_r) ^ (output_mask & state_r));

  always_comb begin
    count_base = restart_r ? '0 : count_r;
    count_nxt  = count_base;
    if (!par && (count_base != '1)) begin
      count_nxt = count_base + 1'b1;
    end
  end

  assign sts.rounds_done = (idx_r == rounds_r);
  assign sts.out_full    = out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      state_r   <= in_plaintext;
      pt_r      <= in_plaintext;
      tk_r      <= cipher_key;
      rounds_r  <= rounds_sat;
      restart_r <= in_restart;
    end else if (cmd.step) begin
      state_r <= slac_pkg::skinny_round(state_r, tk_r, 5'(idx_r));
      tk_r    <= slac_pkg::permute_tk(tk_r);
    end
    if (cmd.finish) begin
      ct_r    <= state_r;
      par_r   <= par;
      total_r <= 32'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ciphertext    = ct_r;
  assign out_approx_parity = par_r;
  assign out_match_total   = total_r;

  a_load_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> idx_r == '0)
    else $error("round index not cleared on load");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> idx_r < rounds_r)
    else $error("round step past configured rounds");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished transaction not presented");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.finish |=> $stable(count_r))
    else $error("match counter moved without a finished transaction");

endmodule

// ===== rtl/core/skinny64_linear_approx_counter.sv =====
// Round-reduced SKINNY-64-64 linear approximation counter, top level.
// out_valid rises after an input transaction once R rounds have run, where R is
// round_count capped at MAX_ROUNDS. A new transaction is taken only once the last
// is finished, as set by the single round unit iterated once per round, and later
// while out_stall holds a finished result. Reset: key 0, rounds 6, masks 0, count 0.
// Instantiates slac_ctrl and slac_dp; depends on slac_pkg.
module skinny64_linear_approx_counter #(
  parameter int COUNT_BITS = slac_pkg::DefCountBits,
  parameter int MAX_ROUNDS = slac_pkg::DefMaxRounds
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [63:0]                  in_plaintext,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [63:0]                  out_ciphertext,
  output logic                         out_approx_parity,
  output logic [31:0]                  out_match_total,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [slac_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]                  cfg_data
);

  logic [63:0] key_r, imask_r, omask_r;
  logic [5:0]  rounds_r;
  slac_pkg::dp_cmd_t cmd;
  slac_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      rounds_r <= slac_pkg::ROUNDS_RESET;
      imask_r  <= '0;
      omask_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slac_pkg::REG_KEY:    key_r    <= cfg_data;
        slac_pkg::REG_ROUNDS: rounds_r <= cfg_data[5:0];
        slac_pkg::REG_IMASK:  imask_r  <= cfg_data;
        slac_pkg::REG_OMASK:  omask_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  slac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  slac_dp #(
    .COUNT_BITS (COUNT_BITS),
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_plaintext      (in_plaintext),
    .in_restart        (in_restart),
    .cipher_key        (key_r),
    .round_count       (rounds_r),
    .input_mask        (imask_r),
    .output_mask       (omask_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ciphertext    (out_ciphertext),
    .out_approx_parity (out_approx_parity),
    .out_match_total   (out_match_total)
  );

endmodule
